/* rtl/core/cunningham_sieve_multiplier_calc_defines.svh */
// Assertion macros for the Cunningham sieve multiplier block.
// Used by the top level only; holds nothing but macros.
`ifndef CUNNINGHAM_SIEVE_MULTIPLIER_CALC_DEFINES_SVH
`define CUNNINGHAM_SIEVE_MULTIPLIER_CALC_DEFINES_SVH

// Assert an implication on the rising clock, disabled in reset.
`define CSMC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Assert a next-cycle implication on the rising clock, disabled in reset.
`define CSMC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/csmc_pkg.sv */
// Package for the Cunningham sieve multiplier block.
// Holds widths, defaults and state encodings; depends on nothing.
package csmc_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned LEN_W           = 5;
  localparam int unsigned MAX_HALF_DEF    = 8;
  localparam logic [LEN_W-1:0] LEN_RESET  = 5'd10;

  // Serial unit operations.
  typedef enum logic [1:0] {
    OP_MOD = 2'd0,
    OP_MUL = 2'd1,
    OP_DIV = 2'd2
  } op_t;

  // Top level sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE, ST_RED, ST_RED_W, ST_EUC, ST_EUC_W, ST_FIX, ST_INS_N, ST_INS_V,
    ST_STEP, ST_STEP_W, ST_OUT
  } state_t;

  // Serial unit states.
  typedef enum logic [1:0] {
    SU_IDLE, SU_RUN, SU_DONE
  } su_state_t;

  // Request to the serial unit.
  typedef struct packed {
    logic        go;
    op_t         op;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] m;
  } su_req_t;

endpackage

/* rtl/core/csmc_serial_unit.sv */
// Bit-serial arithmetic unit: divide, remainder and modular multiply.
// One bit a cycle through shift registers; uses csmc_pkg.
module csmc_serial_unit
  import csmc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  su_req_t           req,
  output logic              done,
  output logic [WORD_W-1:0] quo,
  output logic [WORD_W-1:0] rem
);

  localparam int unsigned CNT_W = $clog2(WORD_W + 1);

  su_state_t         st_r, st_nxt;
  op_t               op_r;
  logic [WORD_W-1:0] sh_r, m_r, b_r, acc_r, q_r;
  logic [CNT_W-1:0]  cnt_r;

  // One step: acc = 2*acc + bit (restoring), or acc = 2*acc + bit*b for multiply.
  // The multiply addend b must already be below m so two subtractions suffice.
  logic [WORD_W:0]   dbl;
  logic [WORD_W+1:0] sum;
  logic [WORD_W+1:0] red1;
  logic              ge1, ge2;
  logic [WORD_W-1:0] acc_nxt;
  logic              qbit;

  always_comb begin
    dbl  = {acc_r, sh_r[WORD_W-1]};
    sum  = {1'b0, acc_r, 1'b0} + ((op_r == OP_MUL && sh_r[WORD_W-1]) ?
           {2'b00, b_r} : {(WORD_W+2){1'b0}});
    if (op_r == OP_MUL) begin
      ge1  = sum >= {2'b00, m_r};
      red1 = ge1 ? sum - {2'b00, m_r} : sum;
      ge2  = red1 >= {2'b00, m_r};
      acc_nxt = ge2 ? red1[WORD_W-1:0] - m_r : red1[WORD_W-1:0];
      qbit = 1'b0;
    end else begin
      ge1  = dbl >= {1'b0, m_r};
      ge2  = 1'b0;
      red1 = {(WORD_W+2){1'b0}};
      acc_nxt = ge1 ? dbl[WORD_W-1:0] - m_r : dbl[WORD_W-1:0];
      qbit = ge1;
    end
  end

  // Next state; a new request may follow directly in the done cycle.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      SU_IDLE: if (req.go) st_nxt = SU_RUN;
      SU_RUN:  if (cnt_r == CNT_W'(WORD_W - 1)) st_nxt = SU_DONE;
      SU_DONE: st_nxt = req.go ? SU_RUN : SU_IDLE;
      default: st_nxt = SU_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= SU_IDLE;
    else        st_r <= st_nxt;
  end

  // Datapath shift registers.
  always_ff @(posedge clk) begin
    if ((st_r == SU_IDLE || st_r == SU_DONE) && req.go) begin
      op_r  <= req.op;
      sh_r  <= req.a;
      b_r   <= req.b;
      m_r   <= req.m;
      acc_r <= '0;
      q_r   <= '0;
      cnt_r <= '0;
    end else if (st_r == SU_RUN) begin
      sh_r  <= {sh_r[WORD_W-2:0], 1'b0};
      acc_r <= acc_nxt;
      q_r   <= {q_r[WORD_W-2:0], qbit};
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

  // Outputs.
  always_comb begin
    done = (st_r == SU_DONE);
    quo  = q_r;
    rem  = acc_r;
  end

endmodule

/* rtl/core/csmc_lists.sv */
// Four multiplier lists with per-slot valid bits, scanned one slot a cycle.
// Uses csmc_pkg.
module csmc_lists
  import csmc_pkg::*;
#(
  parameter int unsigned MAX_HALF = MAX_HALF_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clear,
  input  logic                        ins_go,
  input  logic [1:0]                  ins_list,
  input  logic [WORD_W-1:0]           ins_val,
  input  logic [$clog2(MAX_HALF+1)-1:0] half,
  output logic                        ins_done,
  input  logic [1:0]                  rd_list,
  input  logic [((MAX_HALF > 1) ? $clog2(MAX_HALF) : 1)-1:0] rd_slot,
  output logic [WORD_W-1:0]           rd_val,
  output logic                        rd_vld
);

  localparam int unsigned SW = (MAX_HALF > 1) ? $clog2(MAX_HALF) : 1;
  localparam int unsigned HW = $clog2(MAX_HALF + 1);
  localparam int unsigned N  = 4 * MAX_HALF;

  logic [WORD_W-1:0] val_r [N];
  logic [N-1:0]      vld_r;
  logic              busy_r;
  logic [HW-1:0]     scan_r;

  logic [$clog2(N)-1:0] idx, ridx;
  logic                 stop;

  always_comb begin
    idx  = $clog2(N)'(ins_list) * $clog2(N)'(MAX_HALF) + $clog2(N)'(scan_r[SW-1:0]);
    ridx = $clog2(N)'(rd_list) * $clog2(N)'(MAX_HALF) + $clog2(N)'(rd_slot);
    stop = (scan_r >= half) || !vld_r[idx] || (val_r[idx] == ins_val);
    ins_done = busy_r && stop;
    rd_val = val_r[ridx];
    rd_vld = vld_r[ridx];
  end

  // Insertion scan: one slot per cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      vld_r  <= '0;
      scan_r <= '0;
    end else if (clear) begin
      vld_r  <= '0;
      busy_r <= 1'b0;
    end else if (busy_r) begin
      if (stop) begin
        busy_r <= 1'b0;
        if (scan_r < half && !vld_r[idx]) vld_r[idx] <= 1'b1;
      end else begin
        scan_r <= scan_r + HW'(1);
      end
    end else if (ins_go) begin
      busy_r <= 1'b1;
      scan_r <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy_r && stop && scan_r < half && !vld_r[idx]) val_r[idx] <= ins_val;
  end

endmodule

/* rtl/core/cunningham_sieve_multiplier_calc.sv */
// Cunningham sieve multiplier block, one item at a time. After the accept edge the bit-serial
// unit computes the residue, then a divide and a multiply per Euclid step, then a multiply per
// chain step, where each chain step also has two list scans; the 4*half results (half being
// the chain length halved and rounded up, capped at MAX_HALF_CHAIN) then stream one per cycle,
// each in the cycle after the sequencer addresses it. Busy drops with the last result; the receiver cannot stall.
// Synchronous active-low reset idles the sequencer and sets chain_length to 10.
`include "cunningham_sieve_multiplier_calc_defines.svh"
module cunningham_sieve_multiplier_calc
  import csmc_pkg::*;
#(
  parameter int unsigned MAX_HALF_CHAIN = MAX_HALF_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [WORD_W-1:0] in_prime,
  input  logic [WORD_W-1:0] in_fixed_residue,
  input  logic [WORD_W-1:0] in_half_inverse,
  input  logic              cfg_we,
  input  logic [LEN_W-1:0]  cfg_wdata,
  output logic              out_valid,
  output logic [1:0]        out_list_id,
  output logic [2:0]        out_slot,
  output logic [WORD_W-1:0] out_multiplier,
  output logic              out_present,
  output logic              out_last
);

  localparam int unsigned HW = $clog2(MAX_HALF_CHAIN + 1);
  localparam int unsigned SW = (MAX_HALF_CHAIN > 1) ? $clog2(MAX_HALF_CHAIN) : 1;

  state_t st_r, st_nxt;
  logic [LEN_W-1:0]  len_r;
  logic [WORD_W-1:0] p_r, h_r, r0_r, r1_r, v_r;
  logic [WORD_W:0]   t0_r, t1_r;    // signed-mod-p kept as residues in [0,p)
  logic [LEN_W-1:0]  k_r;
  logic [HW-1:0]     half_r;
  logic [1:0]        ol_r;
  logic [SW-1:0]     os_r;
  logic              ov_r;
  logic [1:0]        ol_q;
  logic [SW-1:0]     os_q;
  logic              last_q;

  su_req_t           req;
  logic              su_done;
  logic [WORD_W-1:0] su_quo, su_rem;
  logic              qmul_r;

  logic              ins_go, ins_done, clr;
  logic [1:0]        ins_list;
  logic [WORD_W-1:0] ins_val, rd_val, neg;
  logic              rd_vld;
  logic [HW-1:0]     half_c;

  // Slots per list, saturated.
  always_comb begin
    half_c = ((({1'b0, len_r} + 6'd1) >> 1) > 6'(MAX_HALF_CHAIN)) ?
             HW'(MAX_HALF_CHAIN) : HW'(({1'b0, len_r} + 6'd1) >> 1);
    neg = (v_r == '0) ? '0 : p_r - v_r;
  end

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n)      len_r <= LEN_RESET;
    else if (cfg_we) len_r <= cfg_wdata;
  end

  csmc_serial_unit u_su (
    .clk(clk), .rst_n(rst_n), .req(req), .done(su_done), .quo(su_quo), .rem(su_rem)
  );

  csmc_lists #(.MAX_HALF(MAX_HALF_CHAIN)) u_lists (
    .clk(clk), .rst_n(rst_n), .clear(clr), .ins_go(ins_go), .ins_list(ins_list),
    .ins_val(ins_val), .half(half_r), .ins_done(ins_done),
    .rd_list(ol_r), .rd_slot(os_r),
    .rd_val(rd_val), .rd_vld(rd_vld)
  );

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:   if (start) st_nxt = (len_r == '0) ? ST_IDLE :
                                    (in_prime == '0) ? ST_OUT : ST_RED;
      ST_RED:    st_nxt = ST_RED_W;
      ST_RED_W:  if (su_done) st_nxt = (su_rem == '0) ? ST_OUT : ST_EUC;
      ST_EUC:    st_nxt = (r1_r == '0) ? ST_FIX : ST_EUC_W;
      ST_EUC_W:  if (su_done && qmul_r) st_nxt = ST_EUC;
      ST_FIX:    st_nxt = (r0_r == WORD_W'(1)) ? ST_INS_N : ST_OUT;
      ST_INS_N:  if (ins_done) st_nxt = ST_INS_V;
      ST_INS_V:  if (ins_done) st_nxt = ST_STEP;
      ST_STEP:   st_nxt = ST_STEP_W;
      ST_STEP_W: if (su_done) st_nxt = (k_r == len_r - LEN_W'(1)) ? ST_OUT : ST_INS_N;
      ST_OUT:    if (ol_r == 2'd3 && os_r == SW'(half_r - HW'(1))) st_nxt = ST_IDLE;
      default:   st_nxt = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    req      = '0;
    req.m    = p_r;
    ins_go   = 1'b0;
    ins_list = '0;
    ins_val  = v_r;
    clr      = (st_r == ST_IDLE) && start;
    busy     = (st_r != ST_IDLE);
    case (st_r)
      ST_RED: begin
        req.go = 1'b1; req.op = OP_MOD; req.a = in_fixed_residue;
        req.a = r1_r;
      end
      ST_EUC: begin
        req.go = (r1_r != '0); req.op = OP_DIV; req.a = r0_r; req.m = r1_r;
      end
      ST_EUC_W: begin
        // After the quotient, form q*t1 mod p.
        req.go = su_done && !qmul_r; req.op = OP_MUL; req.a = su_quo; req.b = t1_r[WORD_W-1:0];
      end
      ST_INS_N: begin
        ins_go = 1'b1; ins_val = neg;
        ins_list = {({1'b0, k_r, 1'b1} >= {2'b00, len_r}), 1'b1};
      end
      ST_INS_V: begin
        ins_go = 1'b1; ins_val = v_r;
        ins_list = {({1'b0, k_r, 1'b0} >= {2'b00, len_r}), 1'b0};
      end
      ST_STEP: begin
        // The half inverse is shifted in bit by bit, so it need not be below p.
        req.go = 1'b1; req.op = OP_MUL; req.a = h_r; req.b = v_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_IDLE;
    else        st_r <= st_nxt;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qmul_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      ov_r <= (st_r == ST_OUT);
      case (st_r)
        ST_IDLE: if (start) begin
          p_r <= in_prime; h_r <= in_half_inverse; r1_r <= in_fixed_residue;
          half_r <= half_c; ol_r <= '0; os_r <= '0; k_r <= '0;
        end
        ST_RED_W: if (su_done) begin
          r0_r <= p_r; r1_r <= su_rem; t0_r <= '0; t1_r <= (WORD_W+1)'(1);
          qmul_r <= 1'b0;
        end
        ST_EUC_W: if (su_done) begin
          if (!qmul_r) begin
            qmul_r <= 1'b1;
            r0_r <= r1_r; r1_r <= su_rem;
          end else begin
            qmul_r <= 1'b0;
            t0_r <= t1_r;
            t1_r <= (t0_r >= {1'b0, su_rem}) ? t0_r - {1'b0, su_rem} :
                    t0_r + {1'b0, p_r} - {1'b0, su_rem};
          end
        end
        ST_FIX: v_r <= t0_r[WORD_W-1:0];
        ST_STEP_W: if (su_done) begin
          v_r <= su_rem; k_r <= k_r + LEN_W'(1);
        end
        ST_OUT: begin
          if (os_r == SW'(half_r - HW'(1))) begin
            os_r <= '0; ol_r <= ol_r + 2'd1;
          end else os_r <= os_r + SW'(1);
        end
        default: ;
      endcase
      ol_q <= ol_r; os_q <= os_r;
      last_q <= (ol_r == 2'd3) && (os_r == SW'(half_r - HW'(1)));
    end
  end

  // Result ports, registered in the cycle after the list read.
  logic [WORD_W-1:0] om_r;
  logic              op_r;
  always_ff @(posedge clk) begin
    om_r <= rd_vld ? rd_val : '0;
    op_r <= rd_vld;
  end

  always_comb begin
    out_valid      = ov_r;
    out_list_id    = ol_q;
    out_slot       = 3'(os_q);
    out_multiplier = om_r;
    out_present    = op_r;
    out_last       = ov_r & last_q;
  end

  `CSMC_ASSERT_IMPL(a_last_on_list3, out_valid && out_last, out_list_id == 2'd3, "last off list 3")
  `CSMC_ASSERT_IMPL(a_empty_zero, out_valid && !out_present, out_multiplier == '0, "empty slot data")
  `CSMC_ASSERT_NEXT(a_busy_after_start, start && !busy && len_r != '0, busy, "start ignored")

endmodule
